FILE: rtl/mts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, codes and the note reload table for the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Score memory depth (a power of two, 16 to 4096).
  localparam int unsigned SCORE_DEPTH = 512;

  // Notes 1 .. NOTE_COUNT-1 sound; 0 is a rest.
  localparam int unsigned NOTE_COUNT  = 37;
  localparam int unsigned TABLE_LEN   = 37;
  localparam int unsigned NOTE_LIMIT  = (NOTE_COUNT < TABLE_LEN) ? NOTE_COUNT : TABLE_LEN;
  localparam logic [7:0]  NOTE_LIM8   = 8'(NOTE_LIMIT);

  localparam logic [7:0]  END_MARK    = 8'hFF;
  localparam logic [15:0] TONE_TOP    = 16'hFFFF;

  // Register reset values
  localparam logic [15:0] TICKS_PER_MS_RST = 16'd1000;
  localparam logic [9:0]  UNIT_MS_RST      = 10'd125;
  localparam logic [7:0]  GAP_MS_RST       = 8'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_MS = 2'd0;
  localparam logic [1:0] CFG_UNIT_MS      = 2'd1;
  localparam logic [1:0] CFG_GAP_MS       = 2'd2;

  // Input operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE,
    PH_GAP,
    PH_DONE
  } phase_t;

  // Score fetch sequencer
  typedef enum logic [1:0] {
    LD_IDLE,
    LD_NOTE,
    LD_DUR
  } ld_t;

  typedef struct packed {
    logic       buzzer;
    logic       playing;
    logic       finished;
    logic [7:0] current_note;
  } res_t;

  // Tone timer reload value per note; entries past the table read zero.
  function automatic logic [15:0] reload_value(input logic [5:0] idx);
    logic [15:0] v;
    case (idx)
      6'd1:  v = 16'd63628;
      6'd2:  v = 16'd63731;
      6'd3:  v = 16'd63835;
      6'd4:  v = 16'd63928;
      6'd5:  v = 16'd64021;
      6'd6:  v = 16'd64103;
      6'd7:  v = 16'd64185;
      6'd8:  v = 16'd64260;
      6'd9:  v = 16'd64331;
      6'd10: v = 16'd64400;
      6'd11: v = 16'd64463;
      6'd12: v = 16'd64528;
      6'd13: v = 16'd64580;
      6'd14: v = 16'd64633;
      6'd15: v = 16'd64684;
      6'd16: v = 16'd64732;
      6'd17: v = 16'd64777;
      6'd18: v = 16'd64820;
      6'd19: v = 16'd64860;
      6'd20: v = 16'd64898;
      6'd21: v = 16'd64934;
      6'd22: v = 16'd64968;
      6'd23: v = 16'd65000;
      6'd24: v = 16'd65030;
      6'd25: v = 16'd65058;
      6'd26: v = 16'd65085;
      6'd27: v = 16'd65110;
      6'd28: v = 16'd65134;
      6'd29: v = 16'd65157;
      6'd30: v = 16'd65178;
      6'd31: v = 16'd65198;
      6'd32: v = 16'd65217;
      6'd33: v = 16'd65235;
      6'd34: v = 16'd65252;
      6'd35: v = 16'd65268;
      6'd36: v = 16'd65283;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/melody_tone_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// Square-wave buzzer melody player driven by a score of note/duration bytes.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in_      | in_valid / in_ready    | operation[1:0], address[8:0], data[7:0]
//  out_     | out_valid / out_ready  | buzzer, playing, finished, current_note[7:0]
//  cfg_     | cfg_we (no wait)       | cfg_index[1:0], cfg_data[15:0]
//
//  A tick, write or unused code is handled in LD_IDLE; push_r is registered
//  from it and the result then enters the queue. A start, or a tick that
//  ends a gap, reads note then duration from the score RAM in LD_NOTE then
//  LD_DUR (LD_NOTE only on the end marker), with in_ready low meanwhile.
//  Results pass a 4-entry queue; input stalls once the queue plus the result
//  in flight hold four. Synchronous reset clears control state, not the RAM.
// ----------------------------------------------------------------------------
module melody_tone_sequencer #(
  // power of two; addresses wrap modulo the depth
  parameter int unsigned SCORE_DEPTH = mts_pkg::SCORE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [8:0]  in_address,
  input  wire logic [7:0]  in_data,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_buzzer,
  output logic             out_playing,
  output logic             out_finished,
  output logic [7:0]       out_current_note,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned AW = $clog2(SCORE_DEPTH);

  // ---------------- configuration registers ----------------
  logic [15:0] ticks_per_ms_r;
  logic [9:0]  unit_ms_r;
  logic [7:0]  gap_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_ms_r <= mts_pkg::TICKS_PER_MS_RST;
      unit_ms_r      <= mts_pkg::UNIT_MS_RST;
      gap_ms_r       <= mts_pkg::GAP_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mts_pkg::CFG_TICKS_PER_MS: ticks_per_ms_r <= cfg_data;
        mts_pkg::CFG_UNIT_MS:      unit_ms_r      <= cfg_data[9:0];
        mts_pkg::CFG_GAP_MS:       gap_ms_r       <= cfg_data[7:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------- player state ----------------
  mts_pkg::phase_t phase_r, phase_nxt;
  mts_pkg::ld_t    ld_r, ld_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [15:0]     tone_r, tone_nxt;
  logic            buzz_r, buzz_nxt;
  logic [7:0]      note_r, note_nxt;
  logic [17:0]     ms_r, ms_nxt;
  logic [15:0]     tick_r, tick_nxt;
  logic            push_r, push_nxt;   // result of the last finished item is ready

  logic            in_xfer;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  // write address wraps modulo the (power of two) depth
  logic [AW+8:0]   addr_ext;
  assign addr_ext  = {{AW{1'b0}}, in_address};
  assign ram_waddr = addr_ext[AW-1:0];

  mts_score_ram #(
    .DEPTH (SCORE_DEPTH),
    .AW    (AW)
  ) u_score_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // duration counting: one tick toward the current ms, ms down on wrap
  logic [15:0] tick_inc;
  logic        ms_hit;
  logic [17:0] ms_cnt;
  logic [15:0] tick_cnt;
  logic        time_done;

  assign tick_inc = tick_r + 16'd1;
  assign ms_hit   = (tick_inc >= ticks_per_ms_r);

  always_comb begin
    ms_cnt   = ms_r;
    tick_cnt = tick_r;
    if (ms_r != 18'd0) begin
      tick_cnt = ms_hit ? 16'd0 : tick_inc;
      ms_cnt   = ms_hit ? (ms_r - 18'd1) : ms_r;
    end
  end
  assign time_done = (ms_cnt == 18'd0);

  // note has a reload entry (not a rest, inside the table)
  logic note_ok;
  assign note_ok = (note_r != 8'd0) && (note_r < mts_pkg::NOTE_LIM8);

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    ld_nxt    = ld_r;
    ptr_nxt   = ptr_r;
    tone_nxt  = tone_r;
    buzz_nxt  = buzz_r;
    note_nxt  = note_r;
    ms_nxt    = ms_r;
    tick_nxt  = tick_r;
    push_nxt  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = ptr_r;

    unique case (ld_r)
      mts_pkg::LD_IDLE: begin
        if (in_xfer) begin
          unique case (in_operation)
            mts_pkg::OP_TICK: begin
              if (phase_r == mts_pkg::PH_NOTE) begin
                if (tone_r == mts_pkg::TONE_TOP) begin
                  if (note_ok) begin
                    tone_nxt = mts_pkg::reload_value(note_r[5:0]);
                    buzz_nxt = ~buzz_r;
                  end else begin
                    tone_nxt = 16'd0;
                  end
                end else begin
                  tone_nxt = tone_r + 16'd1;
                end
                if (time_done) begin
                  phase_nxt = mts_pkg::PH_GAP;
                  ms_nxt    = {10'd0, gap_ms_r};
                  tick_nxt  = 16'd0;
                end else begin
                  ms_nxt   = ms_cnt;
                  tick_nxt = tick_cnt;
                end
                push_nxt = 1'b1;
              end else if (phase_r == mts_pkg::PH_GAP) begin
                ms_nxt   = ms_cnt;
                tick_nxt = tick_cnt;
                if (time_done) begin
                  // gap over: fetch next note at ptr_r
                  ld_nxt = mts_pkg::LD_NOTE;
                end else begin
                  push_nxt = 1'b1;
                end
              end else begin
                push_nxt = 1'b1;
              end
            end
            mts_pkg::OP_WRITE: begin
              ram_we   = 1'b1;
              push_nxt = 1'b1;
            end
            mts_pkg::OP_START: begin
              ptr_nxt   = '0;
              tone_nxt  = 16'd0;
              buzz_nxt  = 1'b0;
              ram_raddr = '0;
              ld_nxt    = mts_pkg::LD_NOTE;
            end
            default: begin
              push_nxt = 1'b1;
            end
          endcase
        end
      end
      mts_pkg::LD_NOTE: begin
        if (ram_rdata == mts_pkg::END_MARK) begin
          phase_nxt = mts_pkg::PH_DONE;
          note_nxt  = 8'd0;
          ms_nxt    = 18'd0;
          tick_nxt  = 16'd0;
          ld_nxt    = mts_pkg::LD_IDLE;
          push_nxt  = 1'b1;
        end else begin
          note_nxt  = ram_rdata;
          ptr_nxt   = ptr_r + AW'(1);
          ram_raddr = ptr_r + AW'(1);
          ld_nxt    = mts_pkg::LD_DUR;
        end
      end
      mts_pkg::LD_DUR: begin
        // 10 x 8 product fits the 18-bit ms counter exactly
        ms_nxt    = 18'(unit_ms_r) * 18'(ram_rdata);
        ptr_nxt   = ptr_r + AW'(1);
        tick_nxt  = 16'd0;
        phase_nxt = mts_pkg::PH_NOTE;
        ld_nxt    = mts_pkg::LD_IDLE;
        push_nxt  = 1'b1;
      end
      default: begin
        ld_nxt = mts_pkg::LD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mts_pkg::PH_IDLE;
      ld_r    <= mts_pkg::LD_IDLE;
      ptr_r   <= '0;
      tone_r  <= 16'd0;
      buzz_r  <= 1'b0;
      note_r  <= 8'd0;
      ms_r    <= 18'd0;
      tick_r  <= 16'd0;
      push_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ld_r    <= ld_nxt;
      ptr_r   <= ptr_nxt;
      tone_r  <= tone_nxt;
      buzz_r  <= buzz_nxt;
      note_r  <= note_nxt;
      ms_r    <= ms_nxt;
      tick_r  <= tick_nxt;
      push_r  <= push_nxt;
    end
  end

  // ---------------- output queue ----------------
  // push_r means the state registers now hold the status after an item;
  // it is captured into the queue at this edge, before the next item lands.
  mts_pkg::res_t res_now;
  mts_pkg::res_t fifo_r [4];
  logic [1:0]    wr_ptr_r, rd_ptr_r;
  logic [2:0]    cnt_r;
  logic          pop;

  assign res_now.buzzer       = buzz_r;
  assign res_now.playing      = (phase_r == mts_pkg::PH_NOTE) || (phase_r == mts_pkg::PH_GAP);
  assign res_now.finished     = (phase_r == mts_pkg::PH_DONE);
  assign res_now.current_note = (phase_r == mts_pkg::PH_NOTE) ? note_r : 8'd0;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_r) begin
      fifo_r[wr_ptr_r] <= res_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (push_r) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop)    rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push_r} - {2'd0, pop};
    end
  end

  assign out_buzzer       = fifo_r[rd_ptr_r].buzzer;
  assign out_playing      = fifo_r[rd_ptr_r].playing;
  assign out_finished     = fifo_r[rd_ptr_r].finished;
  assign out_current_note = fifo_r[rd_ptr_r].current_note;

  // room for the item in flight plus the new one; none during a score fetch
  assign in_ready = (ld_r == mts_pkg::LD_IDLE) && ((cnt_r + {2'd0, push_r}) < 3'd4);

endmodule
`default_nettype wire

FILE: rtl/mts_score_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_score_ram
// Score byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mts_score_ram #(
  parameter int unsigned DEPTH = mts_pkg::SCORE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/mts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks for the melody tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_buzzer,
  input wire logic        out_playing,
  input wire logic        out_finished,
  input wire logic [7:0]  out_current_note
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_buzzer) && $stable(out_playing)
      && $stable(out_finished) && $stable(out_current_note))
    else $error("stalled result changed");

  // playing and finished are exclusive
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_playing && out_finished))
    else $error("playing and finished both set");

  // a note shows only while playing
  a_note_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_playing |-> out_current_note == 8'd0)
    else $error("note shown outside playback");

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result transfer pending after reset");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (.*);
`default_nettype wire
